FILE: rtl/oasc_pkg.sv
// Package for the obstacle avoiding speed controller.
// Holds the shared types, the register map and the reset values of the registers.
// No dependencies.
`default_nettype none

package oasc_pkg;

  localparam int unsigned DistW   = 8;
  localparam int unsigned SpeedW  = 9;
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  typedef logic [DistW-1:0]         dist_t;
  typedef logic signed [SpeedW-1:0] speed_t;

  typedef enum logic [2:0] {
    REG_DANGER_THR    = 3'd0,
    REG_SLOW_THR      = 3'd1,
    REG_SLOW_SPEED    = 3'd2,
    REG_CRUISE_SPEED  = 3'd3,
    REG_REVERSE_SPEED = 3'd4,
    REG_SIDE_OFFSET   = 3'd5
  } oasc_reg_e;

  localparam dist_t  DangerThrRst    = 8'd30;
  localparam dist_t  SlowThrRst      = 8'd50;
  localparam dist_t  SlowSpeedRst    = 8'd30;
  localparam dist_t  CruiseSpeedRst  = 8'd70;
  localparam speed_t ReverseSpeedRst = -9'sd10;
  localparam dist_t  SideOffsetRst   = 8'd20;

  typedef struct packed {
    dist_t  danger_thr;
    dist_t  slow_thr;
    dist_t  slow_speed;
    dist_t  cruise_speed;
    speed_t reverse_speed;
    dist_t  side_offset;
  } oasc_cfg_t;

  typedef enum logic [1:0] {
    ZONE_DANGER = 2'd0,
    ZONE_SLOW   = 2'd1,
    ZONE_CLEAR  = 2'd2
  } oasc_zone_e;

  typedef enum logic [2:0] {
    OP_SET          = 3'd0,
    OP_CRUISE       = 3'd1,
    OP_EASE_BOTH    = 3'd2,
    OP_TENTHS_RIGHT = 3'd3,
    OP_TENTHS_LEFT  = 3'd4
  } oasc_op_e;

  typedef struct packed {
    oasc_op_e op;
    speed_t   left_tgt;
    speed_t   right_tgt;
  } oasc_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/oasc_ifs.sv
// Valid/ready channel interfaces for the sensor input and the wheel speed output.
// Depends on oasc_pkg.
`default_nettype none

interface oasc_in_if;
  import oasc_pkg::*;
  logic  valid;
  logic  ready;
  dist_t front_left_dist;
  dist_t front_right_dist;
  dist_t side_left_dist;
  dist_t side_right_dist;
  modport source(output valid, front_left_dist, front_right_dist, side_left_dist,
                 side_right_dist, input ready);
  modport sink(input valid, front_left_dist, front_right_dist, side_left_dist,
               side_right_dist, output ready);
endinterface

interface oasc_out_if;
  import oasc_pkg::*;
  logic   valid;
  logic   ready;
  speed_t left_wheel_speed;
  speed_t right_wheel_speed;
  modport source(output valid, left_wheel_speed, right_wheel_speed, input ready);
  modport sink(input valid, left_wheel_speed, right_wheel_speed, output ready);
endinterface

`default_nettype wire

FILE: rtl/oasc_cfg_regs.sv
// APB configuration registers of the speed controller.
// Depends on oasc_pkg.
`default_nettype none

module oasc_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [oasc_pkg::ApbAddrW-1:0]    paddr,
  input  wire logic [oasc_pkg::ApbDataW-1:0]    pwdata,
  output logic      [oasc_pkg::ApbDataW-1:0]    prdata,
  output logic                                  pready,
  output oasc_pkg::oasc_cfg_t                   cfg_o
);
  import oasc_pkg::*;

  oasc_cfg_t cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_DANGER_THR:    cfg_d.danger_thr    = pwdata[7:0];
        REG_SLOW_THR:      cfg_d.slow_thr      = pwdata[7:0];
        REG_SLOW_SPEED:    cfg_d.slow_speed    = pwdata[7:0];
        REG_CRUISE_SPEED:  cfg_d.cruise_speed  = pwdata[7:0];
        REG_REVERSE_SPEED: cfg_d.reverse_speed = pwdata[8:0];
        REG_SIDE_OFFSET:   cfg_d.side_offset   = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.danger_thr    <= DangerThrRst;
      cfg_q.slow_thr      <= SlowThrRst;
      cfg_q.slow_speed    <= SlowSpeedRst;
      cfg_q.cruise_speed  <= CruiseSpeedRst;
      cfg_q.reverse_speed <= ReverseSpeedRst;
      cfg_q.side_offset   <= SideOffsetRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (idx)
      REG_DANGER_THR:    prdata = {24'd0, cfg_q.danger_thr};
      REG_SLOW_THR:      prdata = {24'd0, cfg_q.slow_thr};
      REG_SLOW_SPEED:    prdata = {24'd0, cfg_q.slow_speed};
      REG_CRUISE_SPEED:  prdata = {24'd0, cfg_q.cruise_speed};
      REG_REVERSE_SPEED: prdata = {{23{cfg_q.reverse_speed[8]}}, cfg_q.reverse_speed};
      REG_SIDE_OFFSET:   prdata = {24'd0, cfg_q.side_offset};
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/oasc_front.sv
// Front end: classifies the four readings into zones and picks the speed update command.
// Depends on oasc_pkg and oasc_ifs.
`default_nettype none

module oasc_front (
  oasc_in_if.sink                    in_ch,
  input  wire oasc_pkg::oasc_cfg_t   cfg_i,
  output logic                       cmd_valid_o,
  input  wire logic                  cmd_ready_i,
  output oasc_pkg::oasc_cmd_t        cmd_o
);
  import oasc_pkg::*;

  function automatic oasc_zone_e zone_of(dist_t d, dist_t danger_d, dist_t slow_d);
    oasc_zone_e z;
    if (d < danger_d) begin
      z = ZONE_DANGER;
    end else if (d < slow_d) begin
      z = ZONE_SLOW;
    end else begin
      z = ZONE_CLEAR;
    end
    return z;
  endfunction

  oasc_zone_e zfl, zfr, zsl, zsr;
  speed_t     slow, slow_neg, rev, cruise, sl_steer, sr_steer;

  assign zfl = zone_of(in_ch.front_left_dist, cfg_i.danger_thr, cfg_i.slow_thr);
  assign zfr = zone_of(in_ch.front_right_dist, cfg_i.danger_thr, cfg_i.slow_thr);
  assign zsl = zone_of(in_ch.side_left_dist, cfg_i.danger_thr, cfg_i.slow_thr);
  assign zsr = zone_of(in_ch.side_right_dist, cfg_i.danger_thr, cfg_i.slow_thr);

  assign slow     = {1'b0, cfg_i.slow_speed};
  assign slow_neg = -slow;
  assign rev      = cfg_i.reverse_speed;
  assign cruise   = {1'b0, cfg_i.cruise_speed};
  assign sl_steer = {1'b0, in_ch.side_left_dist} - {1'b0, cfg_i.side_offset};
  assign sr_steer = {1'b0, in_ch.side_right_dist} - {1'b0, cfg_i.side_offset};

  assign cmd_valid_o = in_ch.valid;
  assign in_ch.ready = cmd_ready_i;

  always_comb begin
    cmd_o.op        = OP_SET;
    cmd_o.left_tgt  = slow;
    cmd_o.right_tgt = slow;
    if (zfl == ZONE_DANGER && zfr == ZONE_DANGER) begin
      if (zsl == ZONE_DANGER && zsr == ZONE_DANGER) begin
        cmd_o.right_tgt = slow_neg;
      end else begin
        cmd_o.left_tgt  = (in_ch.side_left_dist < in_ch.side_right_dist) ? slow : rev;
        cmd_o.right_tgt = (in_ch.side_left_dist > in_ch.side_right_dist) ? slow : rev;
      end
    end else if (zfl == ZONE_DANGER) begin
      cmd_o.right_tgt = rev;
    end else if (zfr == ZONE_DANGER) begin
      cmd_o.left_tgt = rev;
    end else if (zfl == ZONE_CLEAR && zfr == ZONE_CLEAR) begin
      if ((zsl == ZONE_DANGER || zsr == ZONE_DANGER) && zsl != zsr) begin
        cmd_o.left_tgt  = (zsl == ZONE_DANGER) ? slow : sl_steer;
        cmd_o.right_tgt = (zsr == ZONE_DANGER) ? slow : sr_steer;
      end else begin
        cmd_o.op        = OP_CRUISE;
        cmd_o.left_tgt  = cruise;
        cmd_o.right_tgt = cruise;
      end
    end else if (zfl == zfr) begin
      cmd_o.op = OP_EASE_BOTH;
    end else if (zfr == ZONE_SLOW) begin
      cmd_o.op = OP_TENTHS_RIGHT;
    end else begin
      cmd_o.op = OP_TENTHS_LEFT;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/oasc_queue.sv
// Small command queue between the front end and the back end.
// Depends on oasc_pkg.
`default_nettype none

module oasc_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_valid_i,
  output logic                      push_ready_o,
  input  wire oasc_pkg::oasc_cmd_t  push_cmd_i,
  output logic                      pop_valid_o,
  input  wire logic                 pop_ready_i,
  output oasc_pkg::oasc_cmd_t       pop_cmd_o
);
  import oasc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  oasc_cmd_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/oasc_back.sv
// Back end: applies a command to the kept wheel speeds and registers the result.
// Depends on oasc_pkg and oasc_ifs.
`default_nettype none

module oasc_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cmd_valid_i,
  output logic                      cmd_ready_o,
  input  wire oasc_pkg::oasc_cmd_t  cmd_i,
  oasc_out_if.source                out_ch
);
  import oasc_pkg::*;

  // Average of two speeds, truncated toward zero.
  function automatic speed_t ease_half(speed_t old_v, speed_t tgt);
    logic signed [SpeedW:0] sum;
    logic signed [SpeedW:0] adj;
    sum = {old_v[SpeedW-1], old_v} + {tgt[SpeedW-1], tgt};
    adj = sum + {{SpeedW{1'b0}}, sum[SpeedW]};
    return adj[SpeedW:1];
  endfunction

  // old + 3 * (tgt - old) / 10, truncated toward zero; the division is a
  // multiplication by 6554 / 65536, exact for magnitudes below 2048.
  function automatic speed_t ease_tenths(speed_t old_v, speed_t tgt);
    logic signed [9:0]  diff;
    logic signed [11:0] trip;
    logic [10:0]        mag;
    logic [23:0]        prod;
    logic [7:0]         quo;
    logic signed [9:0]  delta;
    logic signed [9:0]  sum;
    diff  = {tgt[8], tgt} - {old_v[8], old_v};
    trip  = {diff[9], diff[9], diff} + {diff[9], diff, 1'b0};
    mag   = trip[11] ? 11'(-trip) : trip[10:0];
    prod  = 24'(mag) * 24'(13'd6554);
    quo   = prod[23:16];
    delta = trip[11] ? -{2'b00, quo} : {2'b00, quo};
    sum   = {old_v[8], old_v} + delta;
    return sum[8:0];
  endfunction

  speed_t left_q, left_d, right_q, right_d, peak;
  logic   out_valid_q, out_valid_d;
  logic   take;

  assign cmd_ready_o = !out_valid_q || out_ch.ready;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign peak        = (left_q > right_q) ? left_q : right_q;

  always_comb begin
    left_d  = left_q;
    right_d = right_q;
    case (cmd_i.op)
      OP_SET: begin
        left_d  = cmd_i.left_tgt;
        right_d = cmd_i.right_tgt;
      end
      OP_CRUISE: begin
        left_d  = (peak < cmd_i.left_tgt) ? ease_half(peak, cmd_i.left_tgt) : cmd_i.left_tgt;
        right_d = left_d;
      end
      OP_EASE_BOTH: begin
        left_d  = ease_half(left_q, cmd_i.left_tgt);
        right_d = ease_half(right_q, cmd_i.right_tgt);
      end
      OP_TENTHS_RIGHT: begin
        left_d  = ease_half(left_q, cmd_i.left_tgt);
        right_d = ease_tenths(right_q, cmd_i.right_tgt);
      end
      OP_TENTHS_LEFT: begin
        left_d  = ease_tenths(left_q, cmd_i.left_tgt);
        right_d = ease_half(right_q, cmd_i.right_tgt);
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      right_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        left_q  <= left_d;
        right_q <= right_d;
      end
    end
  end

  assign out_ch.valid             = out_valid_q;
  assign out_ch.left_wheel_speed  = left_q;
  assign out_ch.right_wheel_speed = right_q;

endmodule

`default_nettype wire

FILE: rtl/obstacle_avoid_speed_control.sv
// The speed controller takes one transfer of four distance readings per clock while its output
// is taken, and returns one transfer of two wheel speeds per reading, in order. The front end
// sorts the readings into zones and picks an update command in the cycle of the transfer; the
// command waits in a QueueDepth-entry queue; the back end applies it to the kept speeds and
// holds the result in an output register. A stalled output fills the queue and then holds the
// input. A result passes through the queue and the output register before its transfer. The
// user is to write the registers through the APB port only while no item is in flight; the
// block itself does not enforce this.
// Depends on oasc_pkg, oasc_ifs and the oasc_* modules.
`default_nettype none

module obstacle_avoid_speed_control #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  oasc_in_if.sink                               in_ch,
  oasc_out_if.source                            out_ch,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [oasc_pkg::ApbAddrW-1:0]    paddr,
  input  wire logic [oasc_pkg::ApbDataW-1:0]    pwdata,
  output logic      [oasc_pkg::ApbDataW-1:0]    prdata,
  output logic                                  pready
);
  import oasc_pkg::*;

  oasc_cfg_t cfg;
  oasc_cmd_t front_cmd, back_cmd;
  logic      front_valid, front_ready, back_valid, back_ready;

  oasc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  oasc_front u_front (
    .in_ch       (in_ch),
    .cfg_i       (cfg),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  oasc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_cmd_o    (back_cmd)
  );

  oasc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (back_cmd),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

FILE: rtl/oasc_checker.sv
// Port-level checker for the speed controller and its bind to the top level.
// Depends on oasc_pkg.
`default_nettype none

module oasc_checker (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire oasc_pkg::speed_t        out_left,
  input wire oasc_pkg::speed_t        out_right,
  input wire logic                    pready
);
  import oasc_pkg::*;

  logic [7:0] pending_q, pending_d;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_comb begin
    pending_d = pending_q;
    if (in_xfer && !out_xfer) begin
      pending_d = pending_q + 8'd1;
    end else if (out_xfer && !in_xfer) begin
      pending_d = pending_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right))
    else $error("Output transfer dropped or changed while stalled.");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("APB pready went low.");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> pending_q != 8'd0)
    else $error("Result offered with no input transfer outstanding.");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 8'd0 |-> in_ready)
    else $error("Input not ready although nothing is in flight.");

endmodule

bind obstacle_avoid_speed_control oasc_checker u_oasc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_left  (out_ch.left_wheel_speed),
  .out_right (out_ch.right_wheel_speed),
  .pready    (pready)
);

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for the obstacle avoiding speed controller: drives sensor readings,
// predicts the wheel speeds of every transfer and checks them in order, across register settings.
// Depends on oasc_pkg, oasc_ifs and the obstacle_avoid_speed_control RTL.
`timescale 1ns / 100ps

module tb_top;
  import oasc_pkg::*;

  localparam int NumPhases    = 10;
  localparam int PhaseItems   = 180;
  localparam int HoldPhase    = 3;
  localparam int HoldCycles   = 200;
  localparam int StallLimit   = 2000;
  localparam int MaxPrinted   = 40;

  typedef struct packed {
    dist_t fl;
    dist_t fr;
    dist_t sl;
    dist_t sr;
  } reading_t;

  typedef struct packed {
    speed_t left;
    speed_t right;
  } wheels_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                src_valid = 1'b0;
  reading_t            src_item = '0;
  logic [2:0]          src_gap = '0;
  logic                snk_ready = 1'b0;
  logic [2:0]          snk_wait = '0;
  logic                hold_off = 1'b0;
  logic                src_idle_en = 1'b1;
  logic                snk_idle_en = 1'b1;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  reading_t  readings_todo[$];
  wheels_t   speeds_due[$];
  oasc_cfg_t active_cfg = '{DangerThrRst, SlowThrRst, SlowSpeedRst, CruiseSpeedRst,
                            ReverseSpeedRst, SideOffsetRst};
  int        left_kept = 0;
  int        right_kept = 0;
  int        phase_no = 0;
  int        readings_sent = 0;
  int        results_checked = 0;
  int        mismatch_count = 0;
  int        settings_applied = 0;

  oasc_in_if  in_ch();
  oasc_out_if out_ch();

  assign in_ch.valid            = src_valid;
  assign in_ch.front_left_dist  = src_item.fl;
  assign in_ch.front_right_dist = src_item.fr;
  assign in_ch.side_left_dist   = src_item.sl;
  assign in_ch.side_right_dist  = src_item.sr;
  assign out_ch.ready           = snk_ready;

  obstacle_avoid_speed_control DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk_i = ~clk_i;

  function automatic oasc_zone_e zone_of_dist(dist_t d);
    if (d < active_cfg.danger_thr) return ZONE_DANGER;
    if (d < active_cfg.slow_thr) return ZONE_SLOW;
    return ZONE_CLEAR;
  endfunction

  function automatic int half_way(int old, int tgt);
    return (old + tgt) / 2;
  endfunction

  function automatic int three_tenths(int old, int tgt);
    return old + (3 * (tgt - old)) / 10;
  endfunction

  task automatic predict_wheels(input reading_t r);
    oasc_zone_e zfl, zfr, zsl, zsr;
    int sl, sr, slow, cruise, rev, s;
    zfl = zone_of_dist(r.fl);
    zfr = zone_of_dist(r.fr);
    zsl = zone_of_dist(r.sl);
    zsr = zone_of_dist(r.sr);
    sl = int'(r.sl);
    sr = int'(r.sr);
    slow = int'(active_cfg.slow_speed);
    cruise = int'(active_cfg.cruise_speed);
    rev = int'(active_cfg.reverse_speed);
    if (zfl == ZONE_DANGER && zfr == ZONE_DANGER) begin
      if (zsl == ZONE_DANGER && zsr == ZONE_DANGER) begin
        left_kept = slow;
        right_kept = -slow;
      end else begin
        left_kept = (sl < sr) ? slow : rev;
        right_kept = (sl > sr) ? slow : rev;
      end
    end else if (zfl == ZONE_DANGER) begin
      left_kept = slow;
      right_kept = rev;
    end else if (zfr == ZONE_DANGER) begin
      left_kept = rev;
      right_kept = slow;
    end else if (zfl == ZONE_CLEAR && zfr == ZONE_CLEAR) begin
      s = (left_kept > right_kept) ? left_kept : right_kept;
      if ((zsl == ZONE_DANGER) != (zsr == ZONE_DANGER)) begin
        left_kept = (zsl == ZONE_DANGER) ? slow : sl - int'(active_cfg.side_offset);
        right_kept = (zsr == ZONE_DANGER) ? slow : sr - int'(active_cfg.side_offset);
      end else if (s < cruise) begin
        left_kept = half_way(s, cruise);
        right_kept = left_kept;
      end else begin
        left_kept = cruise;
        right_kept = cruise;
      end
    end else if (zfl == zfr) begin
      left_kept = half_way(left_kept, slow);
      right_kept = half_way(right_kept, slow);
    end else if (zfr == ZONE_SLOW) begin
      right_kept = three_tenths(right_kept, slow);
      left_kept = half_way(left_kept, slow);
    end else begin
      right_kept = half_way(right_kept, slow);
      left_kept = three_tenths(left_kept, slow);
    end
    speeds_due.push_back('{left: speed_t'(left_kept), right: speed_t'(right_kept)});
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) $display("%0t ns  MISMATCH  %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_valid <= 1'b0;
      src_gap <= '0;
    end else begin
      if (src_valid && in_ch.ready) begin
        predict_wheels(src_item);
        readings_sent++;
      end
      if (!src_valid || in_ch.ready) begin
        if (src_gap != 0) begin
          src_valid <= 1'b0;
          src_gap <= src_gap - 3'd1;
        end else if (readings_todo.size() != 0) begin
          src_item <= readings_todo.pop_front();
          src_valid <= 1'b1;
          src_gap <= src_idle_en ? 3'($urandom_range(0, 7)) : 3'd0;
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : speed_monitor
    wheels_t    want;
    logic [2:0] stall;
    if (!rst_ni) begin
      snk_ready <= 1'b0;
      snk_wait <= '0;
    end else begin
      stall = snk_idle_en ? 3'($urandom_range(0, 7)) : 3'd0;
      if (out_ch.valid && snk_ready) begin
        if (speeds_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: left %0d right %0d",
                                    out_ch.left_wheel_speed, out_ch.right_wheel_speed));
        end else begin
          want = speeds_due.pop_front();
          if (out_ch.left_wheel_speed !== want.left)
            report_mismatch($sformatf("left wheel %0d, expected %0d",
                                      out_ch.left_wheel_speed, want.left));
          if (out_ch.right_wheel_speed !== want.right)
            report_mismatch($sformatf("right wheel %0d, expected %0d",
                                      out_ch.right_wheel_speed, want.right));
          results_checked++;
        end
        snk_wait <= stall;
        snk_ready <= (stall == 3'd0) && !hold_off;
      end else if (snk_wait != 0) begin
        snk_wait <= snk_wait - 3'd1;
        snk_ready <= 1'b0;
      end else begin
        snk_ready <= !hold_off;
      end
    end
  end

  // The receiver stops taking results for a long stretch so that the block backs up.
  initial begin
    wait (phase_no == HoldPhase);
    repeat (3) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((src_valid && in_ch.ready) || (out_ch.valid && snk_ready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transfer for %0d cycles.", StallLimit);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic reg_write(input oasc_reg_e idx, input logic [ApbDataW-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apply_settings(input oasc_cfg_t c);
    reg_write(REG_DANGER_THR, 32'(c.danger_thr));
    reg_write(REG_SLOW_THR, 32'(c.slow_thr));
    reg_write(REG_SLOW_SPEED, 32'(c.slow_speed));
    reg_write(REG_CRUISE_SPEED, 32'(c.cruise_speed));
    reg_write(REG_REVERSE_SPEED, {23'd0, c.reverse_speed});
    reg_write(REG_SIDE_OFFSET, 32'(c.side_offset));
    active_cfg = c;
    settings_applied++;
  endtask

  task automatic wait_idle();
    while (readings_todo.size() != 0 || src_valid || speeds_due.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_reading(input int fl, input int fr, input int sl, input int sr);
    readings_todo.push_back('{dist_t'(fl), dist_t'(fr), dist_t'(sl), dist_t'(sr)});
  endtask

  function automatic oasc_cfg_t draw_settings();
    oasc_cfg_t c;
    int a, b;
    a = $urandom_range(0, 255);
    b = $urandom_range(0, 255);
    if ($urandom_range(0, 3) != 0 && a > b) begin
      c.danger_thr = dist_t'(b);
      c.slow_thr = dist_t'(a);
    end else begin
      c.danger_thr = dist_t'(a);
      c.slow_thr = dist_t'(b);
    end
    c.slow_speed = dist_t'($urandom_range(0, 255));
    c.cruise_speed = dist_t'($urandom_range(0, 255));
    if ($urandom_range(0, 4) == 0) c.reverse_speed = speed_t'($urandom_range(0, 255));
    else c.reverse_speed = speed_t'(-int'($urandom_range(0, 255)));
    c.side_offset = dist_t'($urandom_range(0, 255));
    return c;
  endfunction

  // Readings cluster in and around the zones of the current thresholds.
  function automatic dist_t pick_dist();
    int m, s, v;
    m = int'(active_cfg.danger_thr);
    s = int'(active_cfg.slow_thr);
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom_range(0, 255);
      3, 4:    v = (m == 0) ? 0 : $urandom_range(0, m - 1);
      5, 6:    v = (s > m) ? $urandom_range(m, s - 1) : $urandom_range(0, 255);
      7, 8:    v = $urandom_range(s, 255);
      default: begin
        case ($urandom_range(0, 5))
          0:       v = m - 1;
          1:       v = m;
          2:       v = s - 1;
          3:       v = s;
          4:       v = 0;
          default: v = 255;
        endcase
      end
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return dist_t'(v);
  endfunction

  task automatic push_random(input int n);
    repeat (n) readings_todo.push_back('{pick_dist(), pick_dist(), pick_dist(), pick_dist()});
  endtask

  initial begin : stimulus
    oasc_cfg_t c;
    int p;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed readings under the reset settings.
    push_reading(0, 0, 0, 0);
    push_reading(0, 0, 200, 40);
    push_reading(29, 29, 40, 200);
    push_reading(0, 0, 100, 100);
    push_reading(10, 255, 0, 0);
    push_reading(255, 29, 255, 255);
    push_reading(50, 50, 255, 255);
    push_reading(255, 255, 255, 255);
    push_reading(255, 255, 5, 255);
    push_reading(200, 40, 255, 255);
    push_reading(40, 40, 100, 100);
    push_reading(255, 255, 5, 255);
    push_reading(255, 255, 255, 255);
    push_reading(255, 255, 255, 0);
    push_reading(255, 255, 10, 40);
    push_reading(255, 255, 10, 10);
    push_reading(255, 255, 45, 255);
    push_reading(0, 200, 100, 100);
    push_reading(200, 40, 100, 100);
    push_reading(30, 49, 50, 255);
    push_reading(49, 50, 29, 30);
    push_reading(0, 0, 0, 0);
    push_reading(40, 200, 0, 0);
    push_random(150);
    wait_idle();

    for (p = 1; p < NumPhases; p++) begin
      case (p)
        1: c = '{8'd0, 8'd255, 8'd255, 8'd0, 9'sd0, 8'd0};
        2: c = '{8'd255, 8'd0, 8'd0, 8'd255, -9'sd255, 8'd255};
        4: c = '{8'd255, 8'd255, 8'd255, 8'd255, -9'sd255, 8'd255};
        5: c = '{8'd0, 8'd0, 8'd0, 8'd0, 9'sd0, 8'd0};
        9: c = '{DangerThrRst, SlowThrRst, SlowSpeedRst, CruiseSpeedRst, 9'sd100,
                 SideOffsetRst};
        default: c = draw_settings();
      endcase
      apply_settings(c);
      src_idle_en = (p % 4) < 2;
      snk_idle_en = (p % 2) == 0;
      phase_no = p;
      push_random(PhaseItems);
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    $display("Checked %0d wheel speed results from %0d sensor readings under %0d settings.",
             results_checked, readings_sent, settings_applied + 1);
    $display("Mismatches found: %0d", mismatch_count);
    if (mismatch_count == 0 && speeds_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/oasc_pkg.sv
rtl/oasc_ifs.sv
rtl/oasc_cfg_regs.sv
rtl/oasc_front.sv
rtl/oasc_queue.sv
rtl/oasc_back.sv
rtl/obstacle_avoid_speed_control.sv
rtl/oasc_checker.sv
bench/tb_top.sv
